>>> design/cba_pkg.sv
// ----------------------------------------------------------------------------
// Chained block allocator package
// Shared constants, command and status codes, word types and width helpers.
// ----------------------------------------------------------------------------
package cba_pkg;

  // Default table geometry.
  localparam int DEF_NUM_BLOCKS  = 256;
  localparam int DEF_BLOCK_BYTES = 1024;

  // Configuration register.
  localparam int         ACT_W     = 9;
  localparam logic [8:0] ACT_RESET = 9'd256;

  // Saturation limits of the result fields.
  localparam int MAX19 = 524287;
  localparam int MAX9  = 511;

  // Command codes.
  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [1:0] STAT_NOT_HEAD = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  // Request word.
  typedef struct packed {
    logic [1:0]  command;
    logic [18:0] byte_count;
    logic [7:0]  start_block;
  } req_t;

  // Result word.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  first_block;
    logic [8:0]  block_count;
    logic [18:0] total_bytes;
    logic [18:0] free_bytes;
    logic [8:0]  file_count;
  } res_t;

  // Per-request part of the result, handed from the sequencer to the output stage.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  first_block;
    logic [8:0]  block_count;
    logic [18:0] total_bytes;
  } res_core_t;

  // Width of one table entry: taken, head, next valid, next link and fill.
  function automatic int entry_w(input int nb, input int bb);
    return 3 + $clog2(nb) + $clog2(bb + 1);
  endfunction

  // Width of a counter that can hold the block count itself.
  function automatic int cnt_w(input int nb);
    return $clog2(nb + 1);
  endfunction

endpackage

>>> design/cba_table.sv
// ----------------------------------------------------------------------------
// Block table memory
// Single-port-write, single-port-read synchronous memory holding one entry
// per block, with registered read data.
// ----------------------------------------------------------------------------
module cba_table #(
  parameter int NUM_BLOCKS  = cba_pkg::DEF_NUM_BLOCKS,
  parameter int BLOCK_BYTES = cba_pkg::DEF_BLOCK_BYTES
) (
  input  logic                                                clk,
  input  logic                                                rd_en,
  input  logic [$clog2(NUM_BLOCKS)-1:0]                       rd_addr,
  output logic [cba_pkg::entry_w(NUM_BLOCKS, BLOCK_BYTES)-1:0] rd_data,
  input  logic                                                wr_en,
  input  logic [$clog2(NUM_BLOCKS)-1:0]                       wr_addr,
  input  logic [cba_pkg::entry_w(NUM_BLOCKS, BLOCK_BYTES)-1:0] wr_data
);

  localparam int ENTRY_W = cba_pkg::entry_w(NUM_BLOCKS, BLOCK_BYTES);

  logic [ENTRY_W-1:0] mem [NUM_BLOCKS];

  // Write port and registered read port; a read of the entry being written
  // returns the old contents.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/cba_ctrl.sv
// ----------------------------------------------------------------------------
// Allocator sequencer
// Clears and recounts the block table, scans it for free blocks on allocate
// and walks chains on free and query, one table read per cycle.
// ----------------------------------------------------------------------------
module cba_ctrl #(
  parameter int NUM_BLOCKS  = cba_pkg::DEF_NUM_BLOCKS,
  parameter int BLOCK_BYTES = cba_pkg::DEF_BLOCK_BYTES
) (
  input  logic                                                clk,
  input  logic                                                rst,
  input  logic                                                start,
  output logic                                                busy,
  input  cba_pkg::req_t                                       request,
  input  logic                                                cfg_we,
  input  logic [cba_pkg::ACT_W-1:0]                           cfg_data,
  output logic                                                mem_rd_en,
  output logic [$clog2(NUM_BLOCKS)-1:0]                       mem_rd_addr,
  input  logic [cba_pkg::entry_w(NUM_BLOCKS, BLOCK_BYTES)-1:0] mem_rd_data,
  output logic                                                mem_wr_en,
  output logic [$clog2(NUM_BLOCKS)-1:0]                       mem_wr_addr,
  output logic [cba_pkg::entry_w(NUM_BLOCKS, BLOCK_BYTES)-1:0] mem_wr_data,
  output logic                                                res_valid,
  output cba_pkg::res_core_t                                  res_core,
  output logic [cba_pkg::cnt_w(NUM_BLOCKS)-1:0]                free_total,
  output logic [cba_pkg::cnt_w(NUM_BLOCKS)-1:0]                file_total
);

  localparam int IDX_W  = $clog2(NUM_BLOCKS);
  localparam int CNT_W  = cba_pkg::cnt_w(NUM_BLOCKS);
  localparam int FILL_W = $clog2(BLOCK_BYTES + 1);
  localparam int PROD_W = CNT_W + FILL_W;
  localparam int CFG_W  = (CNT_W > cba_pkg::ACT_W) ? CNT_W : cba_pkg::ACT_W;

  localparam logic [CNT_W-1:0]  NB_C    = CNT_W'(NUM_BLOCKS);
  localparam logic [FILL_W-1:0] BB_FILL = FILL_W'(BLOCK_BYTES);
  localparam logic [18:0]       BB_19   = 19'(BLOCK_BYTES);

  typedef struct packed {
    logic              taken;
    logic              head;
    logic              has_next;
    logic [IDX_W-1:0]  next;
    logic [FILL_W-1:0] fill;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_RECOUNT,
    S_IDLE,
    S_ALLOC,
    S_TAIL,
    S_WALK,
    S_FINISH
  } state_t;

  state_t state;

  logic [cba_pkg::ACT_W-1:0] active_blocks;
  logic                      recount_pend;
  logic [CNT_W-1:0]          scan_addr;
  logic                      rd_vld;
  logic [IDX_W-1:0]          rd_idx;
  logic [CNT_W-1:0]          free_cnt;
  logic [1:0]                cmd_r;
  logic [7:0]                start_r;
  logic [18:0]               left;
  logic                      pend_vld;
  logic [IDX_W-1:0]          pend_idx;
  logic                      pend_head;
  logic [FILL_W-1:0]         pend_fill;
  logic [IDX_W-1:0]          first_idx;
  logic [CNT_W-1:0]          count;
  logic [IDX_W-1:0]          cur;
  logic [18:0]               sum;
  logic [1:0]                res_status;
  logic [7:0]                res_first;
  logic [18:0]               res_total;

  logic [CFG_W-1:0]  act_ext;
  logic [CNT_W-1:0]  act_used;
  entry_t            rd_ent;
  entry_t            wr_ent;
  logic              issuing;
  logic              pick;
  logic [FILL_W-1:0] fill_now;
  logic [18:0]       left_after;
  logic [PROD_W-1:0] space_prod;
  logic              no_space;
  logic              in_table;
  logic [CNT_W-1:0]  steps_new;
  logic              walk_more;
  logic              head_bad;
  logic [19:0]       sum_add;
  logic [18:0]       sum_sat;

  // Active block count, clamped to the table size and never below one.
  assign act_ext  = CFG_W'(active_blocks);
  assign act_used = (act_ext == '0) ? CNT_W'(1) :
                    (act_ext > CFG_W'(NUM_BLOCKS)) ? NB_C : CNT_W'(act_ext);

  assign rd_ent  = entry_t'(mem_rd_data);
  assign issuing = ((state == S_RECOUNT) || (state == S_ALLOC)) && (scan_addr < act_used);

  // Allocation fill: full blocks until the remainder fits in the last one.
  assign fill_now   = (left >= BB_19) ? BB_FILL : FILL_W'(left);
  assign left_after = left - 19'(fill_now);
  assign pick       = (state == S_ALLOC) && rd_vld && !rd_ent.taken;

  // Free space check on the request.
  assign space_prod = PROD_W'(free_total) * PROD_W'(BLOCK_BYTES);
  assign no_space   = 32'(space_prod) < 32'(request.byte_count);
  assign in_table   = 32'(request.start_block) < NUM_BLOCKS;

  // Chain walk step.
  assign steps_new = count + CNT_W'(1);
  assign walk_more = rd_ent.has_next && (32'(rd_ent.next) < NUM_BLOCKS) &&
                     (32'(steps_new) < NUM_BLOCKS);
  assign head_bad  = (count == '0) && !(rd_ent.taken && rd_ent.head);
  assign sum_add   = {1'b0, sum} + 20'(rd_ent.fill);
  assign sum_sat   = (32'(sum_add) > cba_pkg::MAX19) ? 19'(cba_pkg::MAX19) : sum_add[18:0];

  assign busy      = (state != S_IDLE) || recount_pend;
  assign res_valid = (state == S_FINISH);

  always_comb begin
    res_core.status      = res_status;
    res_core.first_block = res_first;
    res_core.block_count = (32'(count) > cba_pkg::MAX9) ? 9'(cba_pkg::MAX9) : 9'(count);
    res_core.total_bytes = res_total;
  end

  // Table port control.
  always_comb begin
    mem_rd_en   = 1'b0;
    mem_rd_addr = scan_addr[IDX_W-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = scan_addr[IDX_W-1:0];
    wr_ent      = '0;
    case (state)
      S_CLEAR: begin
        mem_wr_en = 1'b1;
      end
      S_RECOUNT: begin
        mem_rd_en = issuing;
      end
      S_IDLE: begin
        mem_rd_en   = start && !busy && in_table &&
                      ((request.command == cba_pkg::CMD_FREE) ||
                       (request.command == cba_pkg::CMD_QUERY));
        mem_rd_addr = IDX_W'(request.start_block);
      end
      S_ALLOC: begin
        mem_rd_en = issuing;
        // The previous pick is written once its successor is known.
        if (pick && pend_vld) begin
          mem_wr_en       = 1'b1;
          mem_wr_addr     = pend_idx;
          wr_ent.taken    = 1'b1;
          wr_ent.head     = pend_head;
          wr_ent.has_next = 1'b1;
          wr_ent.next     = rd_idx;
          wr_ent.fill     = pend_fill;
        end
      end
      S_TAIL: begin
        mem_wr_en       = pend_vld;
        mem_wr_addr     = pend_idx;
        wr_ent.taken    = 1'b1;
        wr_ent.head     = pend_head;
        wr_ent.fill     = pend_fill;
      end
      S_WALK: begin
        if (!head_bad) begin
          mem_wr_en       = (cmd_r == cba_pkg::CMD_FREE);
          mem_wr_addr     = cur;
          wr_ent.has_next = rd_ent.has_next;
          wr_ent.next     = rd_ent.next;
          wr_ent.fill     = rd_ent.fill;
          mem_rd_en       = walk_more;
          mem_rd_addr     = rd_ent.next;
        end
      end
      default: begin
        mem_rd_en = 1'b0;
      end
    endcase
  end

  assign mem_wr_data = wr_ent;

  // Sequencer state and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      active_blocks <= cba_pkg::ACT_RESET;
      recount_pend  <= 1'b0;
      scan_addr     <= '0;
      rd_vld        <= 1'b0;
      free_total    <= '0;
      file_total    <= '0;
      pend_vld      <= 1'b0;
      count         <= '0;
    end else begin
      if (cfg_we) begin
        active_blocks <= cfg_data;
      end
      case (state)
        // Write every entry free after reset, then set the free total to the active block count.
        S_CLEAR: begin
          scan_addr <= scan_addr + CNT_W'(1);
          if (scan_addr == NB_C - CNT_W'(1)) begin
            free_total <= act_used;
            state      <= S_IDLE;
          end
        end
        // Stream the active entries and count the free ones.
        S_RECOUNT: begin
          if (cfg_we) begin
            scan_addr <= '0;
            free_cnt  <= '0;
            rd_vld    <= 1'b0;
          end else begin
            rd_vld <= issuing;
            rd_idx <= scan_addr[IDX_W-1:0];
            if (issuing) begin
              scan_addr <= scan_addr + CNT_W'(1);
            end
            if (rd_vld && !rd_ent.taken) begin
              free_cnt <= free_cnt + CNT_W'(1);
            end
            if (!issuing && !rd_vld) begin
              free_total <= free_cnt;
              state      <= S_IDLE;
            end
          end
        end
        // Start a pending recount, or take a new request, settling the cheap error cases at once.
        S_IDLE: begin
          if (recount_pend) begin
            recount_pend <= 1'b0;
            scan_addr    <= '0;
            free_cnt     <= '0;
            rd_vld       <= 1'b0;
            state        <= S_RECOUNT;
          end else if (start) begin
            cmd_r     <= request.command;
            start_r   <= request.start_block;
            count     <= '0;
            sum       <= '0;
            res_first <= '0;
            res_total <= (request.command == cba_pkg::CMD_ALLOC) ? request.byte_count : '0;
            case (request.command)
              cba_pkg::CMD_ALLOC: begin
                if (request.byte_count == '0) begin
                  res_status <= cba_pkg::STAT_EMPTY;
                  state      <= S_FINISH;
                end else if (no_space) begin
                  res_status <= cba_pkg::STAT_NO_SPACE;
                  state      <= S_FINISH;
                end else begin
                  res_status <= cba_pkg::STAT_OK;
                  left       <= request.byte_count;
                  scan_addr  <= '0;
                  rd_vld     <= 1'b0;
                  pend_vld   <= 1'b0;
                  state      <= S_ALLOC;
                end
              end
              cba_pkg::CMD_FREE, cba_pkg::CMD_QUERY: begin
                if (!in_table) begin
                  res_status <= cba_pkg::STAT_NOT_HEAD;
                  state      <= S_FINISH;
                end else begin
                  res_status <= cba_pkg::STAT_OK;
                  cur        <= IDX_W'(request.start_block);
                  state      <= S_WALK;
                end
              end
              default: begin
                res_status <= cba_pkg::STAT_EMPTY;
                state      <= S_FINISH;
              end
            endcase
          end
        end
        // Ascending scan for free blocks; each pick becomes the pending entry.
        S_ALLOC: begin
          rd_vld <= issuing;
          rd_idx <= scan_addr[IDX_W-1:0];
          if (issuing) begin
            scan_addr <= scan_addr + CNT_W'(1);
          end
          if (pick) begin
            pend_vld  <= 1'b1;
            pend_idx  <= rd_idx;
            pend_head <= (count == '0);
            pend_fill <= fill_now;
            left      <= left_after;
            count     <= count + CNT_W'(1);
            if (count == '0) begin
              first_idx <= rd_idx;
            end
            if (left_after == '0) begin
              state <= S_TAIL;
            end
          end else if (!issuing && !rd_vld) begin
            state <= S_TAIL;
          end
        end
        // Last block of the new chain is written; book-keeping is updated.
        S_TAIL: begin
          rd_vld     <= 1'b0;
          free_total <= free_total - count;
          file_total <= file_total + CNT_W'(1);
          res_first  <= 8'(first_idx);
          state      <= S_FINISH;
        end
        // Follow the chain one entry a cycle, releasing it on free.
        S_WALK: begin
          if (head_bad) begin
            res_status <= cba_pkg::STAT_NOT_HEAD;
            state      <= S_FINISH;
          end else begin
            sum   <= sum_sat;
            count <= steps_new;
            if ((cmd_r == cba_pkg::CMD_FREE) && rd_ent.taken &&
                (CNT_W'(cur) < act_used)) begin
              free_total <= free_total + CNT_W'(1);
            end
            if (walk_more) begin
              cur <= rd_ent.next;
            end else begin
              res_first <= start_r;
              res_total <= (cmd_r == cba_pkg::CMD_QUERY) ? sum_sat : '0;
              if ((cmd_r == cba_pkg::CMD_FREE) && (file_total != '0)) begin
                file_total <= file_total - CNT_W'(1);
              end
              state <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // A register write outside a recount asks for one once the block is idle.
      if (cfg_we && (state != S_RECOUNT)) begin
        recount_pend <= 1'b1;
      end
    end
  end

endmodule

>>> design/cba_result.sv
// ----------------------------------------------------------------------------
// Result output stage
// Scales the free block total to bytes, saturates the counts and holds the
// result word for its one-cycle strobe.
// ----------------------------------------------------------------------------
module cba_result #(
  parameter int NUM_BLOCKS  = cba_pkg::DEF_NUM_BLOCKS,
  parameter int BLOCK_BYTES = cba_pkg::DEF_BLOCK_BYTES
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 res_valid,
  input  cba_pkg::res_core_t                   res_core,
  input  logic [cba_pkg::cnt_w(NUM_BLOCKS)-1:0] free_total,
  input  logic [cba_pkg::cnt_w(NUM_BLOCKS)-1:0] file_total,
  output logic                                 done,
  output cba_pkg::res_t                        result
);

  localparam int CNT_W  = cba_pkg::cnt_w(NUM_BLOCKS);
  localparam int PROD_W = CNT_W + $clog2(BLOCK_BYTES + 1);

  logic [PROD_W-1:0] free_prod;
  cba_pkg::res_t     res_next;

  assign free_prod = PROD_W'(free_total) * PROD_W'(BLOCK_BYTES);

  // Assemble the full word with saturated free bytes and file count.
  always_comb begin
    res_next.status      = res_core.status;
    res_next.first_block = res_core.first_block;
    res_next.block_count = res_core.block_count;
    res_next.total_bytes = res_core.total_bytes;
    res_next.free_bytes  = (32'(free_prod) > cba_pkg::MAX19) ?
                           19'(cba_pkg::MAX19) : 19'(free_prod);
    res_next.file_count  = (32'(file_total) > cba_pkg::MAX9) ?
                           9'(cba_pkg::MAX9) : 9'(file_total);
  end

  // Output register and strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= res_valid;
      if (res_valid) begin
        result <= res_next;
      end
    end
  end

endmodule

>>> design/chained_block_allocator_top.sv
// Allocate scans the table up to the last block it takes, free and query walk the chain,
// and done is registered from the sequencer's result strobe.
// Requests are handled one at a time, set by the single table read port (one entry a cycle).
// Reset: a clearing pass frees every entry, busy held high meanwhile.
// A write to active_blocks starts a recount of the free blocks.
// Results are strobed on done for one cycle and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
// Chained block allocator
// Linked block table allocator: allocates, frees and measures chains of
// fixed-size blocks held in one synchronous table memory.
// ----------------------------------------------------------------------------
module chained_block_allocator_top #(
  parameter int NUM_BLOCKS  = cba_pkg::DEF_NUM_BLOCKS,
  parameter int BLOCK_BYTES = cba_pkg::DEF_BLOCK_BYTES
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  cba_pkg::req_t             request,
  input  logic                      cfg_we,
  input  logic [cba_pkg::ACT_W-1:0] cfg_data,
  output logic                      done,
  output cba_pkg::res_t             result
);

  localparam int IDX_W   = $clog2(NUM_BLOCKS);
  localparam int CNT_W   = cba_pkg::cnt_w(NUM_BLOCKS);
  localparam int ENTRY_W = cba_pkg::entry_w(NUM_BLOCKS, BLOCK_BYTES);

  logic               mem_rd_en;
  logic [IDX_W-1:0]   mem_rd_addr;
  logic [ENTRY_W-1:0] mem_rd_data;
  logic               mem_wr_en;
  logic [IDX_W-1:0]   mem_wr_addr;
  logic [ENTRY_W-1:0] mem_wr_data;
  logic               res_valid;
  cba_pkg::res_core_t res_core;
  logic [CNT_W-1:0]   free_total;
  logic [CNT_W-1:0]   file_total;

  // Block table storage.
  cba_table #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_table (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // Request sequencer.
  cba_ctrl #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .request     (request),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .res_valid   (res_valid),
    .res_core    (res_core),
    .free_total  (free_total),
    .file_total  (file_total)
  );

  // Result word register.
  cba_result #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_result (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res_core   (res_core),
    .free_total (free_total),
    .file_total (file_total),
    .done       (done),
    .result     (result)
  );

endmodule

>>> tb/sv/chained_block_allocator_top_test.sv
// ----------------------------------------------------------------------------
// Chained block allocator testbench
// Drives allocate, free and query command words into the allocator, mirrors
// the block table in a behavioural predictor and checks every result word
// field by field, across several active block settings and idle patterns.
// ----------------------------------------------------------------------------
module chained_block_allocator_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cba_pkg::*;

  localparam int NB             = DEF_NUM_BLOCKS;
  localparam int BB             = DEF_BLOCK_BYTES;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int END_WAIT       = 300;
  localparam int MAX_REPORTS    = 10;
  localparam int NO_HEAD        = -1;

  // Mirror of one table entry.
  typedef struct {
    bit          taken;
    bit          head;
    bit          linked;
    int unsigned next;
    int unsigned fill;
  } block_slot_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  req_t                 request = '0;
  logic                 cfg_we = 1'b0;
  logic [ACT_W-1:0]     cfg_data = '0;
  logic                 done;
  res_t                 result;

  // Predictor state.
  block_slot_t slots [NB];
  int unsigned free_block_count;
  int unsigned file_total;
  int unsigned active_setting;

  // Expected result words, oldest first.
  res_t pending_results [$];

  int unsigned mismatch_count = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned status_seen [4] = '{0, 0, 0, 0};
  int unsigned settings_used = 0;
  int unsigned longest_chain = 0;
  int unsigned quiet_cycles = 0;

  chained_block_allocator_top DUT (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .request  (request),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .done     (done),
    .result   (result)
  );

  // Free-running clock.
  initial begin
    forever #6 clk = ~clk;
  end

  // Active block count as the block uses it, clamped to the table size.
  function automatic int unsigned active_in_use();
    if (active_setting < 1) return 1;
    if (active_setting > NB) return NB;
    return active_setting;
  endfunction

  function automatic void recount_free_blocks();
    int unsigned n;
    n = 0;
    for (int i = 0; i < active_in_use(); i++)
      if (!slots[i].taken) n++;
    free_block_count = n;
  endfunction

  function automatic void clear_block_table();
    foreach (slots[i]) slots[i] = '{0, 0, 0, 0, 0};
    active_setting = ACT_RESET;
    file_total = 0;
    recount_free_blocks();
  endfunction

  // Works out the result word of one command word and updates the mirrored table.
  function automatic res_t predict_request(input req_t rq);
    res_t            r;
    int unsigned     act, need, found, cur, nx, steps, idx;
    longint unsigned left, sum, fb;
    bit              more;
    int unsigned     picks [NB];
    r = '0;
    act = active_in_use();
    if (rq.command == CMD_ALLOC) begin
      r.total_bytes = rq.byte_count;
      if (rq.byte_count == 0) begin
        r.status = STAT_EMPTY;
      end else if (longint'(free_block_count) * BB < rq.byte_count) begin
        r.status = STAT_NO_SPACE;
      end else begin
        need = (rq.byte_count + BB - 1) / BB;
        found = 0;
        for (int i = 0; i < act && found < need; i++)
          if (!slots[i].taken) begin
            picks[found] = i;
            found++;
          end
        if (found < need) begin
          r.status = STAT_NO_SPACE;
        end else begin
          // Link the picked blocks in ascending order; only the last can be partly filled.
          left = rq.byte_count;
          for (int i = 0; i < found; i++) begin
            idx = picks[i];
            slots[idx].taken = 1'b1;
            slots[idx].head = (i == 0);
            slots[idx].linked = (i + 1 < found);
            slots[idx].next = slots[idx].linked ? picks[i + 1] : 0;
            if (left >= BB) begin
              slots[idx].fill = BB;
              left -= BB;
            end else begin
              slots[idx].fill = left;
              left = 0;
            end
          end
          r.status = STAT_OK;
          r.first_block = picks[0];
          r.block_count = (found > MAX9) ? MAX9 : found;
          free_block_count -= found;
          file_total++;
        end
      end
    end else if (rq.command == CMD_FREE || rq.command == CMD_QUERY) begin
      if (!slots[rq.start_block].taken || !slots[rq.start_block].head) begin
        r.status = STAT_NOT_HEAD;
      end else begin
        // Walk the chain, bounded by the table size.
        cur = rq.start_block;
        steps = 0;
        sum = 0;
        more = 1'b1;
        while (more && steps < NB) begin
          nx = slots[cur].next;
          more = slots[cur].linked && nx < NB;
          sum += slots[cur].fill;
          if (rq.command == CMD_FREE) begin
            if (slots[cur].taken && cur < act) free_block_count++;
            slots[cur].taken = 1'b0;
            slots[cur].head = 1'b0;
          end
          steps++;
          cur = nx;
        end
        r.status = STAT_OK;
        r.first_block = rq.start_block;
        r.block_count = (steps > MAX9) ? MAX9 : steps;
        if (rq.command == CMD_QUERY)
          r.total_bytes = (sum > MAX19) ? MAX19 : sum;
        else if (file_total > 0)
          file_total--;
      end
    end else begin
      r.status = STAT_EMPTY;
    end
    fb = longint'(free_block_count) * BB;
    r.free_bytes = (fb > MAX19) ? MAX19 : fb;
    r.file_count = (file_total > MAX9) ? MAX9 : file_total;
    return r;
  endfunction

  // A random head block from the mirrored table, or NO_HEAD when none is stored.
  function automatic int pick_live_head();
    int heads [$];
    foreach (slots[i])
      if (slots[i].taken && slots[i].head) heads.push_back(i);
    if (heads.size() == 0) return NO_HEAD;
    return heads[$urandom_range(heads.size() - 1)];
  endfunction

  function automatic req_t make_word(input logic [1:0] cmd, input int unsigned bytes,
                                     input int unsigned blk);
    req_t rq;
    rq.command = cmd;
    rq.byte_count = bytes;
    rq.start_block = blk;
    return rq;
  endfunction

  // Mostly well-formed traffic on stored files, with some noise on top.
  function automatic req_t make_random_word();
    req_t        rq;
    int unsigned sel, sz;
    int          head;
    rq = req_t'({$urandom, $urandom});
    sel = $urandom_range(99);
    if (sel < 40) begin
      rq.command = CMD_ALLOC;
      sz = $urandom_range(99);
      if (sz < 70)      rq.byte_count = $urandom_range(4096, 1);
      else if (sz < 88) rq.byte_count = $urandom_range(32768, 1);
      else if (sz < 95) rq.byte_count = $urandom_range(NB * BB, 1);
      else if (sz < 97) rq.byte_count = 0;
      else              rq.byte_count = $urandom_range(MAX19, NB * BB + 1);
    end else if (sel < 95) begin
      rq.command = (sel < 70) ? CMD_FREE : CMD_QUERY;
      head = pick_live_head();
      if (head != NO_HEAD && $urandom_range(9) != 0) rq.start_block = head;
    end else begin
      rq.command = 2'd3;
    end
    return rq;
  endfunction

  // Sends one word; start is left high so a back-to-back word needs no toggle.
  task automatic send_request(input req_t rq);
    res_t want;
    start <= 1'b1;
    request <= rq;
    do @(posedge clk); while (busy);
    want = predict_request(rq);
    pending_results.push_back(want);
    words_sent++;
    status_seen[want.status]++;
    if (want.block_count > longest_chain) longest_chain = want.block_count;
    @(negedge clk);
  endtask

  // Lowers start and waits for every expected word and for the block to go idle.
  task automatic settle_block();
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
    @(negedge clk);
  endtask

  task automatic write_active_blocks(input logic [ACT_W-1:0] val);
    settle_block();
    cfg_we <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    active_setting = val;
    recount_free_blocks();
    settings_used++;
    @(negedge clk);
    cfg_we <= 1'b0;
    // Give the recount time to raise busy before the next word.
    repeat (2) @(negedge clk);
  endtask

  // Random sender gap; the odd word also waits for the block to drain.
  task automatic sender_gap(input int unsigned idle_pct);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(99) < 3) begin
      settle_block();
    end else begin
      while ($urandom_range(99) < idle_pct && gap < 40) gap++;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Requests on an empty table, a zero-byte allocate and an unknown command.
  task automatic test_empty_table();
    send_request(make_word(CMD_QUERY, 0, 0));
    send_request(make_word(CMD_FREE, MAX19, 255));
    send_request(make_word(CMD_ALLOC, 0, 255));
    send_request(make_word(2'd3, MAX19, 255));
  endtask

  // Single byte, exact block, one over a block, and sizes beyond the free space.
  task automatic test_alloc_sizes();
    send_request(make_word(CMD_ALLOC, 1, 0));
    send_request(make_word(CMD_ALLOC, BB, 0));
    send_request(make_word(CMD_ALLOC, BB + 1, 0));
    send_request(make_word(CMD_ALLOC, MAX19, 0));
    send_request(make_word(CMD_ALLOC, NB * BB, 0));
    send_request(make_word(CMD_QUERY, 0, 2));
    send_request(make_word(CMD_QUERY, 0, 3));
  endtask

  // A hole in the table makes the next file's chain skip over taken blocks.
  task automatic test_fragmented_chain();
    send_request(make_word(CMD_FREE, 0, 1));
    send_request(make_word(CMD_ALLOC, 3000, 0));
    send_request(make_word(CMD_QUERY, 0, 1));
    send_request(make_word(CMD_FREE, 0, 0));
    send_request(make_word(CMD_FREE, 0, 2));
    send_request(make_word(CMD_FREE, 0, 1));
  endtask

  // One file over the whole table, then no room for even one byte.
  task automatic test_full_table();
    send_request(make_word(CMD_ALLOC, NB * BB, 0));
    send_request(make_word(CMD_ALLOC, 1, 0));
    send_request(make_word(CMD_QUERY, 0, 0));
    send_request(make_word(CMD_FREE, 0, 0));
  endtask

  // Clamping of the active count, and freeing blocks above the active count.
  task automatic test_active_limits();
    write_active_blocks(9'd0);
    send_request(make_word(CMD_ALLOC, BB, 0));
    send_request(make_word(CMD_ALLOC, 1, 0));
    send_request(make_word(CMD_FREE, 0, 0));
    write_active_blocks(9'd256);
    send_request(make_word(CMD_ALLOC, 20000, 0));
    write_active_blocks(9'd8);
    send_request(make_word(CMD_FREE, 0, 0));
    write_active_blocks(9'd511);
  endtask

  task automatic test_random_traffic(input int unsigned words, input int unsigned idle_pct);
    for (int i = 0; i < words; i++) begin
      send_request(make_random_word());
      sender_gap(idle_pct);
    end
  endtask

  // Main sequence.
  initial begin
    clear_block_table();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_alloc_sizes();
    test_fragmented_chain();
    test_full_table();
    test_active_limits();

    write_active_blocks(9'd256);
    test_random_traffic(200, 0);
    write_active_blocks(9'd37);
    test_random_traffic(200, 70);
    write_active_blocks(9'd1);
    test_random_traffic(60, 22);
    write_active_blocks(9'd511);
    test_random_traffic(160, 22);
    write_active_blocks($urandom_range(511, 0));
    test_random_traffic(200, 0);

    settle_block();
    repeat (END_WAIT) @(posedge clk);

    $display("Summary: %0d words checked: %0d ok, %0d out of space, %0d bad head, %0d empty",
             words_checked, status_seen[STAT_OK], status_seen[STAT_NO_SPACE],
             status_seen[STAT_NOT_HEAD], status_seen[STAT_EMPTY]);
    $display("Summary: %0d active block settings, longest chain %0d blocks, %0d mismatches",
             settings_used, longest_chain, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0 && words_checked == words_sent)
      $display("chained_block_allocator_top test passed");
    else
      $display("chained_block_allocator_top test failed");
    $finish;
  end

  // Checks each result word against the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result word with nothing expected: status %0d first %0d",
                   $realtime, result.status, result.first_block);
      end else begin
        want = pending_results.pop_front();
        words_checked++;
        if (result.status !== want.status || result.first_block !== want.first_block ||
            result.block_count !== want.block_count ||
            result.total_bytes !== want.total_bytes ||
            result.free_bytes !== want.free_bytes ||
            result.file_count !== want.file_count) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: word %0d expected st %0d fb %0d cnt %0d tot %0d free %0d files %0d",
                     $realtime, words_checked, want.status, want.first_block,
                     want.block_count, want.total_bytes, want.free_bytes, want.file_count);
            $display("%0t: word %0d actual   st %0d fb %0d cnt %0d tot %0d free %0d files %0d",
                     $realtime, words_checked, result.status, result.first_block,
                     result.block_count, result.total_bytes, result.free_bytes,
                     result.file_count);
          end
        end
      end
    end
  end

  // Ends a run in which nothing has moved for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no word accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("chained_block_allocator_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> sim.f
design/cba_pkg.sv
design/cba_table.sv
design/cba_ctrl.sv
design/cba_result.sv
design/chained_block_allocator_top.sv
tb/sv/chained_block_allocator_top_test.sv
